@@ rtl/core/etb_pkg.sv @@
// ----------------------------------------------------------------------------
// etb_pkg: shared types and constants for the event timer bank
// Command and response structs, timer entry layout, opcodes and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package etb_pkg;

  localparam int NUM_TIMERS = 8;

  localparam int MODE_W  = 3;
  localparam int IDX_W   = 3;
  localparam int CNT_W16 = 16;
  localparam int FLAG_W  = 8;

  // opcodes
  localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESTART = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RESET   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CHECK   = 3'd6;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [IDX_W-1:0]   timer_index;
    logic [CNT_W16-1:0] period_value;
    logic               is_recurring;
    logic               clear_on_check;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]   slot_index;
    logic               slot_found;
    logic [CNT_W16-1:0] count_value;
    logic               has_expired;
    logic [FLAG_W-1:0]  flag_vector;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W16-1:0] count;
    logic [CNT_W16-1:0] period;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ONE
  } state_t;

endpackage

@@ rtl/core/event_timer_bank.sv @@
// ----------------------------------------------------------------------------
// event_timer_bank: bank of 16-bit down-counting event timers
// Timer count/period pairs live in one synchronous RAM; flags in flops.
// ----------------------------------------------------------------------------
// Sequencing: tick and start walk the RAM one entry per cycle, from entry 0
//   to the last timer (start ends early at the first free timer); all other
//   commands do one RAM read, then a write-back where they change the entry.
// Handshake: one command at a time; the next start is taken at the edge
//   that ends the done cycle. busy is high while a command is in flight.
//   The receiver cannot stall done.
// Reset: all counts, periods and flags read as zero right after rst.
module event_timer_bank (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  etb_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output etb_pkg::rsp_t rsp
);
  import etb_pkg::*;

  localparam int ADDR_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int ISS_W  = $clog2(NUM_TIMERS + 1);

  state_t               state, state_next;
  cmd_t                 cmd_q, cmd_next;
  rsp_t                 rsp_q, rsp_next;
  logic                 done_q, done_next;
  logic [ISS_W-1:0]     issue_cnt, issue_next;
  logic [ADDR_W-1:0]    pipe_idx, pipe_next;
  logic [NUM_TIMERS-1:0] flags, flags_next;

  // timer RAM, with per-entry valid so reset reads as zero
  entry_t               mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] entry_valid;
  entry_t               rd_data;
  logic                 rd_hit;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  entry_t               wr_data;
  entry_t               cur;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_hit  <= entry_valid[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done_q    <= 1'b0;
      flags     <= '0;
      issue_cnt <= '0;
      pipe_idx  <= '0;
    end else begin
      state     <= state_next;
      done_q    <= done_next;
      flags     <= flags_next;
      issue_cnt <= issue_next;
      pipe_idx  <= pipe_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q <= cmd_next;
    rsp_q <= rsp_next;
  end

  always_comb begin
    logic              idx_ok;
    logic              finish;
    logic              found;
    logic [CNT_W16-1:0] dec;
    logic [CNT_W16-1:0] count_out;
    logic              expired;

    state_next = state;
    cmd_next   = cmd_q;
    rsp_next   = rsp_q;
    done_next  = 1'b0;
    issue_next = issue_cnt;
    pipe_next  = pipe_idx;
    flags_next = flags;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = pipe_idx;
    cur        = rd_hit ? rd_data : '0;
    wr_data    = cur;
    finish     = 1'b0;
    found      = 1'b0;
    count_out  = '0;
    expired    = 1'b0;
    dec        = cur.count - 16'd1;
    idx_ok     = int'(cmd_q.timer_index) < NUM_TIMERS;

    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd_next = cmd;
          if (cmd.mode == MODE_TICK || cmd.mode == MODE_START) begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            pipe_next  = '0;
            issue_next = ISS_W'(1);
            state_next = ST_WALK;
          end else begin
            rd_en      = int'(cmd.timer_index) < NUM_TIMERS;
            rd_addr    = cmd.timer_index[ADDR_W-1:0];
            pipe_next  = cmd.timer_index[ADDR_W-1:0];
            state_next = ST_ONE;
          end
        end
      end

      ST_WALK: begin
        // read of the next entry overlaps write-back of the current one
        if (int'(issue_cnt) < NUM_TIMERS) begin
          rd_en      = 1'b1;
          rd_addr    = ADDR_W'(issue_cnt);
          pipe_next  = ADDR_W'(issue_cnt);
          issue_next = issue_cnt + ISS_W'(1);
        end
        finish = (pipe_idx == ADDR_W'(NUM_TIMERS - 1));
        if (cmd_q.mode == MODE_TICK) begin
          if (cur.count != '0) begin
            wr_en = 1'b1;
            if (dec == '0) begin
              wr_data.count        = cur.period;
              flags_next[pipe_idx] = 1'b1;
            end else begin
              wr_data.count = dec;
            end
          end
        end else if (cur.count == '0 && cur.period == '0) begin
          wr_en                = 1'b1;
          wr_data.count        = cmd_q.period_value;
          wr_data.period       = cmd_q.is_recurring ? cmd_q.period_value : '0;
          flags_next[pipe_idx] = 1'b0;
          found                = 1'b1;
          finish               = 1'b1;
        end
      end

      ST_ONE: begin
        finish = 1'b1;
        if (idx_ok) begin
          case (cmd_q.mode)
            MODE_STOP: begin
              wr_en   = 1'b1;
              wr_data = '0;
            end
            MODE_RESTART: begin
              wr_en                = 1'b1;
              wr_data.count        = cmd_q.period_value;
              wr_data.period       = cmd_q.is_recurring ? cmd_q.period_value
                                                        : cur.period;
              flags_next[pipe_idx] = 1'b0;
            end
            MODE_RESET: begin
              wr_en                = 1'b1;
              wr_data.count        = cur.period;
              flags_next[pipe_idx] = 1'b0;
            end
            MODE_READ: begin
              count_out = cur.count;
            end
            MODE_CHECK: begin
              expired = flags[pipe_idx];
              if (cmd_q.clear_on_check) begin
                flags_next[pipe_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (finish) begin
      state_next           = ST_IDLE;
      done_next            = 1'b1;
      rsp_next.slot_index  = found ? IDX_W'(pipe_idx) : '0;
      rsp_next.slot_found  = found;
      rsp_next.count_value = count_out;
      rsp_next.has_expired = expired;
      rsp_next.flag_vector = FLAG_W'(flags_next);
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = done_q;
  assign rsp  = rsp_q;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for event_timer_bank
// Drives timer commands over the start/busy handshake, predicts every
// response from a local copy of the timer bank and checks each done strobe.
// ----------------------------------------------------------------------------
module tb;
  import etb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;
  localparam logic [MODE_W-1:0] MODE_NONE = 3'd7;  // unused opcode, ignored by the bank

  // Shadow of the timer bank; queues the response each accepted command owes.
  class timer_bank_shadow;
    logic [CNT_W16-1:0] counts  [NUM_TIMERS];
    logic [CNT_W16-1:0] periods [NUM_TIMERS];
    logic [FLAG_W-1:0]  flags;
    rsp_t               owed_rsp [$];
    int                 errors;
    int                 reported;

    function new();
      for (int i = 0; i < NUM_TIMERS; i++) begin
        counts[i]  = '0;
        periods[i] = '0;
      end
      flags    = '0;
      errors   = 0;
      reported = 0;
    endfunction

    function void load(int i, logic [CNT_W16-1:0] p, logic recur);
      counts[i] = p;
      if (recur) periods[i] = p;
      flags[i] = 1'b0;
    endfunction

    function void accept_cmd(cmd_t c);
      rsp_t r;
      int   idx;
      bit   in_range;
      r        = '0;
      idx      = int'(c.timer_index);
      in_range = idx < NUM_TIMERS;
      case (c.mode)
        MODE_TICK: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (counts[i] != 0) begin
              counts[i] = counts[i] - 1'b1;
              if (counts[i] == 0) begin
                counts[i] = periods[i];
                flags[i]  = 1'b1;
              end
            end
          end
        end
        MODE_START: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (counts[i] == 0 && periods[i] == 0) begin
              load(i, c.period_value, c.is_recurring);
              r.slot_index = i[IDX_W-1:0];
              r.slot_found = 1'b1;
              break;
            end
          end
        end
        MODE_STOP: begin
          if (in_range) begin
            counts[idx]  = '0;
            periods[idx] = '0;
          end
        end
        MODE_RESTART: begin
          if (in_range) load(idx, c.period_value, c.is_recurring);
        end
        MODE_RESET: begin
          if (in_range) begin
            counts[idx] = periods[idx];
            flags[idx]  = 1'b0;
          end
        end
        MODE_READ: begin
          if (in_range) r.count_value = counts[idx];
        end
        MODE_CHECK: begin
          if (in_range) begin
            r.has_expired = flags[idx];
            if (c.clear_on_check) flags[idx] = 1'b0;
          end
        end
        default: ;
      endcase
      r.flag_vector = flags;
      owed_rsp.push_back(r);
    endfunction

    function void check_rsp(rsp_t got);
      rsp_t want;
      if (owed_rsp.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: response with nothing outstanding: %p", got);
        end
        return;
      end
      want = owed_rsp.pop_front();
      if (got.slot_index !== want.slot_index || got.slot_found !== want.slot_found ||
          got.count_value !== want.count_value || got.has_expired !== want.has_expired ||
          got.flag_vector !== want.flag_vector) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("ERROR: slot %0d/%0d found %0b/%0b count %0d/%0d expired %0b/%0b flags %h/%h",
                   want.slot_index, got.slot_index, want.slot_found, got.slot_found,
                   want.count_value, got.count_value, want.has_expired, got.has_expired,
                   want.flag_vector, got.flag_vector);
        end
      end
    endfunction

    function int outstanding();
      return owed_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  timer_bank_shadow bank = new();
  int cycles = 0;

  event_timer_bank u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cmd  (cmd),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) bank.check_rsp(rsp);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic cmd_t mk_cmd(logic [MODE_W-1:0] m, int idx, int p, bit recur, bit clr);
    cmd_t c;
    c.mode           = m;
    c.timer_index    = idx[IDX_W-1:0];
    c.period_value   = p[CNT_W16-1:0];
    c.is_recurring   = recur;
    c.clear_on_check = clr;
    return c;
  endfunction

  // Mostly short periods so timers expire and free up; some long and edge values.
  function automatic int pick_period();
    int sel;
    sel = $urandom_range(19);
    if (sel < 11) return $urandom_range(4, 1);
    if (sel < 14) return $urandom_range(40, 5);
    if (sel < 16) return 0;
    if (sel < 18) return $urandom_range(65535);
    return 65535;
  endfunction

  function automatic cmd_t pick_cmd();
    int   w;
    cmd_t c;
    logic [MODE_W-1:0] m;
    w = $urandom_range(99);
    if (w < 38)      m = MODE_TICK;
    else if (w < 53) m = MODE_START;
    else if (w < 60) m = MODE_STOP;
    else if (w < 68) m = MODE_RESTART;
    else if (w < 75) m = MODE_RESET;
    else if (w < 86) m = MODE_READ;
    else if (w < 98) m = MODE_CHECK;
    else             m = MODE_NONE;
    c = mk_cmd(m, $urandom_range(NUM_TIMERS - 1), pick_period(),
               $urandom_range(99) < 70, $urandom_range(1));
    return c;
  endfunction

  // start stays high after a transfer; the next call either idles or reloads cmd.
  task automatic send_cmd(input cmd_t c, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    bank.accept_cmd(c);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (bank.outstanding() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int n, input int idle_pct);
    for (int k = 0; k < n; k++) send_cmd(pick_cmd(), idle_pct);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty bank, allocation order, zero period, expiry, flags, full bank
    send_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0), 0);
    send_cmd(mk_cmd(MODE_CHECK, 7, 0, 0, 1), 0);
    send_cmd(mk_cmd(MODE_TICK, 0, 0, 0, 0), 0);        // all counts zero: nothing moves
    send_cmd(mk_cmd(MODE_START, 0, 2, 1, 0), 0);
    send_cmd(mk_cmd(MODE_START, 0, 1, 0, 0), 0);
    send_cmd(mk_cmd(MODE_START, 0, 0, 1, 0), 0);       // zero period: slot reported, stays free
    send_cmd(mk_cmd(MODE_START, 0, 65535, 1, 0), 0);   // gets the same slot again
    send_cmd(mk_cmd(MODE_TICK, 0, 0, 0, 0), 0);
    send_cmd(mk_cmd(MODE_TICK, 0, 0, 0, 0), 0);
    send_cmd(mk_cmd(MODE_CHECK, 1, 0, 0, 0), 0);
    send_cmd(mk_cmd(MODE_CHECK, 1, 0, 0, 1), 0);
    send_cmd(mk_cmd(MODE_READ, 0, 0, 0, 0), 0);
    send_cmd(mk_cmd(MODE_RESET, 0, 0, 0, 0), 0);
    send_cmd(mk_cmd(MODE_RESTART, 1, 3, 0, 0), 0);     // non-recurring: period kept
    send_cmd(mk_cmd(MODE_RESTART, 3, 65535, 1, 1), 0);
    send_cmd(mk_cmd(MODE_STOP, 2, 0, 0, 0), 0);
    send_cmd(mk_cmd(MODE_NONE, 7, 65535, 1, 1), 0);
    for (int i = 0; i < 8; i++)                        // fill the bank, then three more
      send_cmd(mk_cmd(MODE_START, 7 - i, 32768 + i, 1, 0), 0);
    drain();

    run_random(700, 28);
    drain();
    run_random(500, 78);
    drain();
    run_random(800, 0);
    drain();
    repeat (DRAIN_WAIT) @(posedge clk);

    if (bank.errors == 0 && bank.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
